### sv/s2t_pkg.sv
// Shared constants, register indexes and control/status types for the space-run to tab converter.
package s2t_pkg;

	// Block sizing
	localparam int NUM_STOPS   = 6;
	localparam int DEFAULT_GAP = 8;   // grid past the last stop; a power of two, at least 2
	localparam int GAP_W       = $clog2(DEFAULT_GAP);
	localparam int MAX_PENDING = 63;
	localparam int PEND_W      = $clog2(MAX_PENDING + 1);
	localparam int COL_W       = 16;
	localparam int CNT_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int BYTE_W      = 8;

	localparam logic [COL_W-1:0] COL_MAX = '1;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_A     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_B     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_C     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_D     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_E     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_F     = 3'd6;

	// Register reset values
	localparam logic [CNT_W-1:0] STOP_COUNT_RST = 3'd1;
	localparam logic [COL_W-1:0] STOP_RST [NUM_STOPS] = '{
		16'd8, 16'd16, 16'd24, 16'd32, 16'd40, 16'd48
	};

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take_space;   // count one more pending space
		logic capture;      // latch the non-space request
		logic calc_target;  // register the next stop after the column
		logic emit_run;     // put one tab or space into the output register
		logic emit_byte;    // put the latched byte into the output register
		logic finish;       // request done, clear the overflow flag
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_space;     // incoming request is a space
		logic in_end;       // incoming request is an end item
		logic pend_zero;    // no spaces pending
		logic run_done;     // this emit step empties the run
		logic eot;          // latched request is an end item
		logic out_free;     // output register can take a result
	} status_t;

endpackage

### sv/s2t_datapath.sv
// Datapath: configuration registers, column and run state, stop search, output register.
module s2t_datapath import s2t_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [BYTE_W-1:0]     in_byte,
	input  logic                  end_of_text,
	input  logic                  out_stall,
	input  cmd_t                  cmd,
	output status_t               status,
	output logic                  out_valid,
	output logic [BYTE_W-1:0]     out_byte,
	output logic                  run_last,
	output logic                  spaces_dropped
);

	logic [CNT_W-1:0]  stop_count_q;
	logic [COL_W-1:0]  stop_q [NUM_STOPS];
	logic [COL_W-1:0]  col_q;
	logic [PEND_W-1:0] pend_q;
	logic              ovf_q;
	logic [BYTE_W-1:0] byte_q;
	logic              eot_q;
	logic [COL_W:0]    target_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              run_last_q;
	logic              dropped_q;

	logic [CNT_W-1:0]  used;
	logic              hit;
	logic [COL_W-1:0]  base;
	logic [GAP_W-1:0]  rem;
	logic [COL_W:0]    next_stop;
	logic [COL_W:0]    run_sum;
	logic [COL_W:0]    gap;
	logic              is_tab;
	logic [COL_W-1:0]  col_inc;
	logic [COL_W-1:0]  col_run;
	logic [PEND_W-1:0] pend_run;
	logic              out_free;

	// Configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= STOP_COUNT_RST;
			for (int i = 0; i < NUM_STOPS; i++) begin
				stop_q[i] <= STOP_RST[i];
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_STOP_COUNT: stop_count_q <= cfg_data[CNT_W-1:0];
				REG_STOP_A:     stop_q[0] <= cfg_data[COL_W-1:0];
				REG_STOP_B:     stop_q[1] <= cfg_data[COL_W-1:0];
				REG_STOP_C:     stop_q[2] <= cfg_data[COL_W-1:0];
				REG_STOP_D:     stop_q[3] <= cfg_data[COL_W-1:0];
				REG_STOP_E:     stop_q[4] <= cfg_data[COL_W-1:0];
				REG_STOP_F:     stop_q[5] <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	// Next stop strictly beyond the column: first listed stop past it,
	// else the default grid continuing from the last listed stop
	always_comb begin
		used      = (stop_count_q > CNT_W'(NUM_STOPS)) ? CNT_W'(NUM_STOPS) : stop_count_q;
		hit       = 1'b0;
		base      = COL_W'(DEFAULT_GAP);
		next_stop = '0;
		for (int i = 0; i < NUM_STOPS; i++) begin
			if (!hit && (CNT_W'(i) < used)) begin
				if (col_q < stop_q[i]) begin
					hit       = 1'b1;
					next_stop = {1'b0, stop_q[i]};
				end else begin
					base = stop_q[i];
				end
			end
		end
		rem = col_q[GAP_W-1:0] - base[GAP_W-1:0];
		if (!hit) begin
			if ((used == '0) && (col_q < COL_W'(DEFAULT_GAP))) begin
				next_stop = (COL_W+1)'(DEFAULT_GAP);
			end else begin
				next_stop = {1'b0, col_q} + ((COL_W+1)'(DEFAULT_GAP) - (COL_W+1)'(rem));
			end
		end
	end

	// One flush step: a tab when the run reaches the stop, else a space
	assign run_sum  = {1'b0, col_q} + (COL_W+1)'(pend_q);
	assign is_tab   = run_sum >= target_q;
	assign gap      = target_q - {1'b0, col_q};
	assign col_inc  = (col_q == COL_MAX) ? COL_MAX : col_q + 1'b1;
	assign col_run  = is_tab ? (target_q[COL_W] ? COL_MAX : target_q[COL_W-1:0]) : col_inc;
	assign pend_run = is_tab ? pend_q - gap[PEND_W-1:0] : pend_q - PEND_W'(1);
	assign out_free = !out_valid_q || !out_stall;

	// Status to the controller
	always_comb begin
		status.in_space  = !end_of_text && (in_byte == CH_SPACE);
		status.in_end    = end_of_text;
		status.pend_zero = (pend_q == '0);
		status.run_done  = (pend_run == '0);
		status.eot       = eot_q;
		status.out_free  = out_free;
	end

	// Column, pending run and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= COL_W'(1);
			pend_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.take_space) begin
				if (pend_q >= PEND_W'(MAX_PENDING)) begin
					ovf_q <= 1'b1;
				end else begin
					pend_q <= pend_q + 1'b1;
				end
			end
			if (cmd.emit_run) begin
				col_q  <= col_run;
				pend_q <= pend_run;
			end
			if (cmd.emit_byte) begin
				col_q <= (byte_q == CH_NEWLINE) ? COL_W'(1) : col_inc;
			end
			if (cmd.finish) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// Latched request and stop target
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= in_byte;
			eot_q  <= end_of_text;
		end
		if (cmd.calc_target) begin
			target_q <= next_stop;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_run || cmd.emit_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_run) begin
			out_byte_q <= is_tab ? CH_TAB : CH_SPACE;
			run_last_q <= (pend_run == '0) && eot_q;
			dropped_q  <= ovf_q;
		end else if (cmd.emit_byte) begin
			out_byte_q <= byte_q;
			run_last_q <= 1'b1;
			dropped_q  <= ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign run_last       = run_last_q;
	assign spaces_dropped = dropped_q;

	// Checks
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(MAX_PENDING))
		else $error("pending space count above limit");

	a_target_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_run |-> (target_q > {1'b0, col_q}))
		else $error("stop target not beyond column");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_run || cmd.emit_byte) |-> out_free)
		else $error("result written over a waiting result");

endmodule

### sv/s2t_ctrl.sv
// Controller: sequences capture, stop search and result emission for each request.
module s2t_ctrl import s2t_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE      = 2'd0;
	localparam logic [1:0] ST_TARGET    = 2'd1;
	localparam logic [1:0] ST_EMIT_RUN  = 2'd2;
	localparam logic [1:0] ST_EMIT_BYTE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (status.in_space) begin
						cmd.take_space = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						if (!status.pend_zero) begin
							state_nxt = ST_TARGET;
						end else if (!status.in_end) begin
							state_nxt = ST_EMIT_BYTE;
						end else begin
							cmd.finish = 1'b1;
						end
					end
				end
			end
			ST_TARGET: begin
				cmd.calc_target = 1'b1;
				state_nxt       = ST_EMIT_RUN;
			end
			ST_EMIT_RUN: begin
				if (status.out_free) begin
					cmd.emit_run = 1'b1;
					if (!status.run_done) begin
						state_nxt = ST_TARGET;
					end else if (status.eot) begin
						cmd.finish = 1'b1;
						state_nxt  = ST_IDLE;
					end else begin
						state_nxt = ST_EMIT_BYTE;
					end
				end
			end
			ST_EMIT_BYTE: begin
				if (status.out_free) begin
					cmd.emit_byte = 1'b1;
					cmd.finish    = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Checks
	a_target_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TARGET) |-> !status.pend_zero)
		else $error("stop search with no pending spaces");

	a_space_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status.in_space) |=> (state_q == ST_IDLE))
		else $error("space request left idle state");

	a_run_to_target: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_run && !status.run_done) |=> cmd.calc_target)
		else $error("unfinished run did not search next stop");

endmodule

### sv/space_run_to_tab_converter_top.sv
// Space-run to tab converter: a space is counted as pending and gives no result.
// Any other request is accepted, then each tab or space of the pending run takes a stop search
// and then an emit step, and the passed byte, if the request is not an end item, takes its own emit step.
// Results leave through an output register; output stall holds the flush in place.
// The controller takes one request at a time; the stop search over the list sets the step.
// Asynchronous active-low reset: column 1, no pending spaces, registers at their reset values.
module space_run_to_tab_converter_top import s2t_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BYTE_W-1:0]     in_byte,
	input  logic                  end_of_text,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BYTE_W-1:0]     out_byte,
	output logic                  run_last,
	output logic                  spaces_dropped
);

	cmd_t    cmd;
	status_t status;

	s2t_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	s2t_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_byte        (in_byte),
		.end_of_text    (end_of_text),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.out_byte       (out_byte),
		.run_last       (run_last),
		.spaces_dropped (spaces_dropped)
	);

endmodule

### bench/space_run_to_tab_converter_top_test.sv
// Self-checking testbench for the space-run to tab converter: random text against a predictor.
module space_run_to_tab_converter_top_test;
	import s2t_pkg::*;

	localparam int DRAIN_CYCLES = 20;     // covers space counting and a short flush
	localparam int QUIET_LIMIT  = 5000;   // cycles with no transfer before giving up
	localparam int HOLD_CYCLES  = 400;    // long output stall
	localparam int MAX_PRINTS   = 100;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              eot;
	} text_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              spaces_dropped;
	} out_rec_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [BYTE_W-1:0]     in_byte = '0;
	logic                  end_of_text = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [BYTE_W-1:0]     out_byte;
	logic                  run_last;
	logic                  spaces_dropped;

	// Pending requests and the results they should produce
	text_req_t text_q [$];
	out_rec_t  emit_q [$];

	// Mirror of the block's registers and state
	bit [CNT_W-1:0]   stop_cnt = STOP_COUNT_RST;
	logic [COL_W-1:0] stop_col [NUM_STOPS] = STOP_RST;
	bit [31:0]        col_now = 1;
	int               spaces_held = 0;
	bit               sat_flag = 1'b0;

	int  errors = 0;
	int  in_accepts = 0;
	int  in_offers = 0;
	int  tx_pct = 15;
	int  rx_pct = 52;
	int  hold_left = 0;
	bit  hold_go = 1'b0;
	bit  hold_used = 1'b0;
	int  quiet = 0;

	space_run_to_tab_converter_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.end_of_text    (end_of_text),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.run_last       (run_last),
		.spaces_dropped (spaces_dropped)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string what);
		if (errors < MAX_PRINTS)
			$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// First stop strictly beyond column c
	function automatic bit [31:0] next_stop(bit [31:0] c);
		int        used;
		bit [31:0] base;
		bit [31:0] rem;
		used = (stop_cnt > NUM_STOPS) ? NUM_STOPS : int'(stop_cnt);
		base = DEFAULT_GAP;
		for (int i = 0; i < used; i++) begin
			if (c < stop_col[i])
				return 32'(stop_col[i]);
			base = 32'(stop_col[i]);
		end
		if (used == 0 && c < base)
			return base;
		rem = (c - base) % DEFAULT_GAP;
		return c + (DEFAULT_GAP - rem);
	endfunction

	// Work out the results of one request and queue them
	function automatic void entab_request(text_req_t r);
		out_rec_t  burst [$];
		bit [31:0] target;
		if (!r.eot && r.ch == CH_SPACE) begin
			if (spaces_held >= MAX_PENDING)
				sat_flag = 1'b1;
			else
				spaces_held++;
			return;
		end
		// flush the run: tab when the stop is reachable, else one space
		while (spaces_held > 0) begin
			target = next_stop(col_now);
			if (col_now + spaces_held >= target) begin
				burst.push_back('{CH_TAB, 1'b0, sat_flag});
				spaces_held -= int'(target - col_now);
				col_now = (target > COL_MAX) ? 32'(COL_MAX) : target;
			end else begin
				burst.push_back('{CH_SPACE, 1'b0, sat_flag});
				spaces_held--;
				col_now = (col_now + 1 > COL_MAX) ? 32'(COL_MAX) : col_now + 1;
			end
		end
		if (!r.eot) begin
			burst.push_back('{r.ch, 1'b0, sat_flag});
			if (r.ch == CH_NEWLINE)
				col_now = 1;
			else
				col_now = (col_now + 1 > COL_MAX) ? 32'(COL_MAX) : col_now + 1;
		end
		sat_flag = 1'b0;
		if (burst.size() > 0)
			burst[burst.size()-1].run_last = 1'b1;
		foreach (burst[i])
			emit_q.push_back(burst[i]);
	endfunction

	// Sample transfers: check results, mirror register writes, predict requests
	always @(posedge clk or negedge arst_n) begin
		out_rec_t exp_rec;
		if (!arst_n) begin
			stop_cnt    = STOP_COUNT_RST;
			stop_col    = STOP_RST;
			col_now     = 1;
			spaces_held = 0;
			sat_flag    = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (emit_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result byte %0d", out_byte));
				end else begin
					exp_rec = emit_q.pop_front();
					if (out_byte !== exp_rec.out_byte || run_last !== exp_rec.run_last ||
							spaces_dropped !== exp_rec.spaces_dropped)
						report_mismatch($sformatf(
							"byte %0d/%0d last %0b/%0b dropped %0b/%0b (got/exp)",
							out_byte, exp_rec.out_byte, run_last, exp_rec.run_last,
							spaces_dropped, exp_rec.spaces_dropped));
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_STOP_COUNT: stop_cnt = cfg_data[CNT_W-1:0];
					REG_STOP_A: stop_col[0] = cfg_data;
					REG_STOP_B: stop_col[1] = cfg_data;
					REG_STOP_C: stop_col[2] = cfg_data;
					REG_STOP_D: stop_col[3] = cfg_data;
					REG_STOP_E: stop_col[4] = cfg_data;
					REG_STOP_F: stop_col[5] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				entab_request('{in_byte, end_of_text});
				in_accepts++;
			end
		end
	end

	// Request driver: holds a request until taken, idles at random
	always @(negedge clk) begin
		text_req_t r;
		if (arst_n && (!in_valid || in_accepts == in_offers)) begin
			if (text_q.size() > 0 && $urandom_range(99) >= tx_pct) begin
				r = text_q.pop_front();
				in_valid    <= 1'b1;
				in_byte     <= r.ch;
				end_of_text <= r.eot;
				in_offers++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long output hold-off, started once on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// Result receiver stall
	always @(negedge clk) begin
		out_stall <= (hold_left != 0) || (rx_pct > 0 && $urandom_range(99) < rx_pct);
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		while (text_q.size() != 0 || in_valid || emit_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_char(logic [BYTE_W-1:0] c);
		text_q.push_back('{c, 1'b0});
	endtask

	// Text-like stream: words, space runs, newlines, tabs, end items and noise
	task automatic gen_text(int n);
		int cnt;
		int kind;
		int len;
		cnt = 0;
		while (cnt < n) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				len = $urandom_range(6, 1);
				repeat (len) push_char(BYTE_W'($urandom_range(126, 33)));
			end else if (kind < 70) begin
				len = $urandom_range(12, 1);
				repeat (len) push_char(CH_SPACE);
			end else if (kind < 78) begin
				len = 1;
				push_char(CH_NEWLINE);
			end else if (kind < 84) begin
				len = 1;
				push_char(CH_TAB);
			end else if (kind < 88) begin
				len = 1;
				text_q.push_back('{8'($urandom_range(255)), 1'b1});
			end else if (kind < 92) begin
				len = $urandom_range(70, 20);
				repeat (len) push_char(CH_SPACE);
			end else begin
				len = 1;
				push_char(BYTE_W'($urandom_range(255)));
			end
			cnt += len;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed text under the reset stops
		push_char("A");
		repeat (6) push_char(CH_SPACE);      // run reaching the first stop: one tab
		push_char(8'hFF);
		repeat (2) push_char(CH_SPACE);
		text_q.push_back('{8'h41, 1'b1});   // end item flushes the two spaces
		text_q.push_back('{8'hFF, 1'b1});   // end item with nothing pending
		push_char(CH_TAB);
		push_char(CH_NEWLINE);
		push_char(8'h00);
		push_char(8'h80);
		push_char(8'h7F);
		push_char(CH_SPACE);
		push_char(CH_NEWLINE);
		gen_text(25);
		wait_drained();

		// No explicit stops; upper data bits are ignored
		write_reg(REG_STOP_COUNT, 16'hFFF8);
		repeat (70) push_char(CH_SPACE);     // saturates the pending count
		push_char("x");
		hold_go = 1'b1;
		gen_text(30);
		wait_drained();

		// Full ascending list
		write_reg(REG_STOP_COUNT, 16'd6);
		write_reg(REG_STOP_A, 16'd3);
		write_reg(REG_STOP_B, 16'd5);
		write_reg(REG_STOP_C, 16'd9);
		write_reg(REG_STOP_D, 16'd12);
		write_reg(REG_STOP_E, 16'd20);
		write_reg(REG_STOP_F, 16'd30);
		gen_text(30);
		wait_drained();

		// Count above the list size, extreme stop values
		tx_pct = 52;
		rx_pct = 15;
		write_reg(REG_STOP_COUNT, 16'd7);
		write_reg(REG_STOP_A, 16'd1);
		write_reg(REG_STOP_B, 16'd2);
		write_reg(REG_STOP_C, 16'd4);
		write_reg(REG_STOP_D, 16'd7);
		write_reg(REG_STOP_E, 16'd11);
		write_reg(REG_STOP_F, 16'hFFFF);
		gen_text(30);
		wait_drained();

		// Stops out of order, one of them zero
		write_reg(REG_STOP_COUNT, 16'd3);
		write_reg(REG_STOP_A, 16'd20);
		write_reg(REG_STOP_B, 16'd0);
		write_reg(REG_STOP_C, 16'd10);
		gen_text(30);
		wait_drained();

		// Write to an unused index must be ignored
		tx_pct = 0;
		rx_pct = 0;
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_STOP_COUNT, 16'd2);
		write_reg(REG_STOP_A, 16'hFFFF);
		write_reg(REG_STOP_B, 16'd4);
		gen_text(30);
		wait_drained();

		write_reg(REG_STOP_COUNT, 16'd5);
		write_reg(REG_STOP_A, 16'd4);
		write_reg(REG_STOP_B, 16'd8);
		write_reg(REG_STOP_C, 16'd12);
		write_reg(REG_STOP_D, 16'd16);
		write_reg(REG_STOP_E, 16'd24);
		gen_text(45);
		text_q.push_back('{8'h00, 1'b1});
		wait_drained();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
sv/s2t_pkg.sv
sv/s2t_datapath.sv
sv/s2t_ctrl.sv
sv/space_run_to_tab_converter_top.sv
bench/space_run_to_tab_converter_top_test.sv
